// ===== rtl/lsba_pkg.sv =====
package lsba_pkg;

  localparam int unsigned SEG_IDX_W  = 8;
  localparam int unsigned BLOCK_W    = 12;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned SCAN_CHUNK = 8;
  localparam int unsigned SCAN_SH    = 3;

  localparam logic [SEG_IDX_W-1:0] NO_SEGMENT = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_FLUSH     = 3'd1,
    OP_TEST      = 3'd2,
    OP_SET       = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_CLEAR_ALL = 3'd5,
    OP_RESCAN    = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SEG_IDX_W-1:0] segment_index;
  } in_item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]   block_number;
    logic                 segment_occupied;
    logic                 segment_closed;
    logic [SEG_IDX_W-1:0] closed_segment;
    logic [SEG_IDX_W-1:0] next_segment;
    logic                 status;
  } out_item_t;

  typedef struct packed {
    logic                 done;
    logic [SEG_IDX_W-1:0] seg;
  } scan_res_t;

endpackage

// ===== rtl/lsba_if.sv =====
interface lsba_in_if import lsba_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsba_out_if import lsba_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lsba_scan.sv =====
module lsba_scan import lsba_pkg::*; #(
  parameter int unsigned SEGMENTS = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SEGMENTS-1:0] map_i,
  output scan_res_t           res_o
);

  localparam int unsigned NCHUNK = (SEGMENTS + SCAN_CHUNK - 1) / SCAN_CHUNK;
  localparam int unsigned CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned PAD_W  = NCHUNK * SCAN_CHUNK;

  logic                  busy_q, busy_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [PAD_W-1:0]      padded;
  logic [SCAN_CHUNK-1:0] chunk;
  logic [SCAN_SH-1:0]    enc;
  logic                  hit;
  logic                  last;

  // bits past the last segment read as occupied so they are never picked
  always_comb begin
    padded = '1;
    padded[SEGMENTS-1:0] = map_i;
    chunk = padded[{idx_q, {SCAN_SH{1'b0}}} +: SCAN_CHUNK];
  end

  // lowest free bit of the current chunk
  always_comb begin
    enc = '0;
    for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        enc = SCAN_SH'(i);
      end
    end
  end

  assign hit  = ~&chunk;
  assign last = (idx_q == CW'(NCHUNK - 1));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      if (hit || last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + CW'(1);
      end
    end
  end

  always_comb begin
    res_o.done = busy_q && (hit || last);
    res_o.seg  = hit ? SEG_IDX_W'({idx_q, enc}) : NO_SEGMENT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

// ===== rtl/log_segment_block_allocator.sv =====
// Flow: an accepted beat passes through EXEC, then SCAN for ops that close a
// segment or rescan, then WRITE, which waits until the output register can load.
// A new beat is taken only in IDLE, after WRITE has loaded the last result; the
// first-fit scan checks 8 bitmap entries per cycle in the shared scan unit.
// Reset: all segments free, current segment 0, slot 0, no result pending.
module log_segment_block_allocator import lsba_pkg::*; #(
  parameter int unsigned SEGMENTS           = 255,
  parameter int unsigned BLOCKS_PER_SEGMENT = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  lsba_in_if.sink       in_i,
  lsba_out_if.source    out_o
);

  localparam int unsigned SEG_W  = $clog2(SEGMENTS);
  localparam int unsigned SLOT_W = $clog2(BLOCKS_PER_SEGMENT);
  localparam int unsigned BN_W   = 16;

  state_e state_q, state_d;

  logic [SEGMENTS-1:0]  map_q, map_d;
  logic [SEG_IDX_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;

  logic [OP_W-1:0]      op_q;
  logic [SEG_IDX_W-1:0] idx_q;
  out_item_t            res_q, res_d;
  out_item_t            out_q, out_d;
  logic                 ov_q, ov_d;

  logic                 accept;
  logic                 need_scan;
  logic                 can_load;
  logic                 has_cur;
  logic                 idx_ok;
  logic [BN_W-1:0]      prod;
  logic [BN_W-1:0]      bn;
  scan_res_t            scan;

  lsba_scan #(
    .SEGMENTS(SEGMENTS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(need_scan),
    .map_i  (map_q),
    .res_o  (scan)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  assign can_load = !ov_q || out_o.ready;
  assign has_cur  = (cur_q < SEG_IDX_W'(SEGMENTS));
  assign idx_ok   = (idx_q < SEG_IDX_W'(SEGMENTS));
  assign prod     = BN_W'({1'b0, cur_q} + 9'd1) * BN_W'(BLOCKS_PER_SEGMENT);
  assign bn       = prod + BN_W'(slot_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = need_scan ? ST_SCAN : ST_WRITE;
      end
      ST_SCAN: begin
        if (scan.done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    map_d     = map_q;
    cur_d     = cur_q;
    slot_d    = slot_q;
    res_d     = res_q;
    out_d     = out_q;
    ov_d      = ov_q && !out_o.ready;
    need_scan = 1'b0;
    case (state_q)
      ST_EXEC: begin
        res_d = '0;
        case (op_e'(op_q))
          OP_ALLOC: begin
            if (!has_cur) begin
              res_d.status = 1'b1;
            end else begin
              res_d.block_number = bn[BLOCK_W-1:0];
              if (slot_q == SLOT_W'(BLOCKS_PER_SEGMENT - 1)) begin
                // segment full: mark it and find the next one
                map_d[cur_q[SEG_W-1:0]] = 1'b1;
                res_d.segment_closed    = 1'b1;
                res_d.closed_segment    = cur_q;
                slot_d                  = '0;
                need_scan               = 1'b1;
              end else begin
                slot_d = slot_q + SLOT_W'(1);
              end
            end
          end
          OP_FLUSH: begin
            if (has_cur && (slot_q != '0)) begin
              map_d[cur_q[SEG_W-1:0]] = 1'b1;
              res_d.segment_closed    = 1'b1;
              res_d.closed_segment    = cur_q;
              slot_d                  = '0;
              need_scan               = 1'b1;
            end
          end
          OP_TEST: begin
            if (idx_ok) res_d.segment_occupied = map_q[idx_q[SEG_W-1:0]];
          end
          OP_SET: begin
            if (idx_ok) map_d[idx_q[SEG_W-1:0]] = 1'b1;
          end
          OP_CLEAR: begin
            if (idx_ok) map_d[idx_q[SEG_W-1:0]] = 1'b0;
          end
          OP_CLEAR_ALL: begin
            map_d  = '0;
            cur_d  = '0;
            slot_d = '0;
          end
          OP_RESCAN: begin
            slot_d    = '0;
            need_scan = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (scan.done) cur_d = scan.seg;
      end
      ST_WRITE: begin
        if (can_load) begin
          out_d              = res_q;
          out_d.next_segment = cur_q;
          ov_d               = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      map_q   <= '0;
      cur_q   <= '0;
      slot_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      map_q   <= map_d;
      cur_q   <= cur_d;
      slot_q  <= slot_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.data.op;
      idx_q <= in_i.data.segment_index;
    end
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule
